// ===== hdl/mle_pkg.sv =====
`default_nettype none

package mle_pkg;

  localparam int POS_W        = 5;
  localparam int CHAR_W       = 7;
  localparam int BYTE_W       = 8;
  localparam int KIND_W       = 2;
  localparam int CAPACITY_DEF = 16;

  localparam logic [BYTE_W-1:0] MASK_RESET = 8'd42;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  localparam logic [BYTE_W-1:0] KEY_PREFIX0 = 8'd0;
  localparam logic [BYTE_W-1:0] KEY_PREFIX1 = 8'd224;
  localparam logic [BYTE_W-1:0] KEY_LEFT    = 8'd75;
  localparam logic [BYTE_W-1:0] KEY_RIGHT   = 8'd77;
  localparam logic [BYTE_W-1:0] KEY_ENTER   = 8'd13;
  localparam logic [BYTE_W-1:0] KEY_BKSP    = 8'd8;
  localparam logic [BYTE_W-1:0] KEY_SPACE   = 8'd32;
  localparam logic [BYTE_W-1:0] KEY_TILDE   = 8'd126;
  localparam logic [BYTE_W-1:0] END_BYTE    = 8'd0;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_SHL  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [POS_W-1:0]  cursor;
    logic [CHAR_W-1:0] code;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/mle_cell.sv =====
`default_nettype none

module mle_cell #(
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire mle_pkg::cell_ctl_t        ctl,
  input  wire logic [mle_pkg::CHAR_W-1:0] left_in,
  input  wire logic [mle_pkg::CHAR_W-1:0] right_in,
  output logic      [mle_pkg::CHAR_W-1:0] data_out
);

  localparam logic [mle_pkg::POS_W-1:0] POS  = mle_pkg::POS_W'(IDX);
  localparam logic [mle_pkg::POS_W-1:0] POS1 = mle_pkg::POS_W'(IDX + 1);

  logic [mle_pkg::CHAR_W-1:0] data_r;
  logic [mle_pkg::CHAR_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      mle_pkg::CELL_INS: begin
        if (POS == ctl.cursor) begin
          data_nxt = ctl.code;
        end else if (POS > ctl.cursor) begin
          data_nxt = left_in;
        end
      end
      mle_pkg::CELL_DEL: begin
        if (POS1 >= ctl.cursor) begin
          data_nxt = right_in;
        end
      end
      mle_pkg::CELL_SHL: begin
        data_nxt = right_in;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

`default_nettype wire

// ===== hdl/mle_seq.sv =====
`default_nettype none

module mle_seq #(
  parameter int CAPACITY = mle_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mle_pkg::BYTE_W-1:0]  in_key_code,
  input  wire logic [mle_pkg::BYTE_W-1:0]  mask_char,
  input  wire logic [mle_pkg::CHAR_W-1:0]  head_char,
  output mle_pkg::cell_ctl_t               cell_ctl,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [mle_pkg::KIND_W-1:0]  out_kind,
  output logic      [mle_pkg::BYTE_W-1:0]  out_byte,
  output logic                             out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE8  = 3'd1;
  localparam logic [2:0] S_MASK  = 3'd2;
  localparam logic [2:0] S_SPACE = 3'd3;
  localparam logic [2:0] S_BS1   = 3'd4;
  localparam logic [2:0] S_BSN   = 3'd5;
  localparam logic [2:0] S_TEXT  = 3'd6;
  localparam logic [2:0] S_END   = 3'd7;

  localparam logic [2:0] OP_LEFT  = 3'd0;
  localparam logic [2:0] OP_RIGHT = 3'd1;
  localparam logic [2:0] OP_ENTER = 3'd2;
  localparam logic [2:0] OP_BKSP  = 3'd3;
  localparam logic [2:0] OP_INS   = 3'd4;

  localparam int PW = mle_pkg::POS_W;
  localparam logic [PW-1:0] ONE = PW'(1);
  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic          pend_r, pend_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [mle_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [mle_pkg::BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;

  logic adv;
  logic printable;

  assign adv       = !out_valid_r || !out_stall;
  assign printable = (in_key_code >= mle_pkg::KEY_SPACE) && (in_key_code <= mle_pkg::KEY_TILDE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    cell_ctl.op     = mle_pkg::CELL_HOLD;
    cell_ctl.cursor = cur_r;
    cell_ctl.code   = in_key_code[mle_pkg::CHAR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (pend_r) begin
            pend_nxt = 1'b0;
            if (in_key_code == mle_pkg::KEY_LEFT && cur_r != '0) begin
              cur_nxt   = cur_r - ONE;
              op_nxt    = OP_LEFT;
              state_nxt = S_PRE8;
            end else if (in_key_code == mle_pkg::KEY_RIGHT && cur_r < len_r) begin
              cur_nxt   = cur_r + ONE;
              op_nxt    = OP_RIGHT;
              cnt_nxt   = ONE;
              state_nxt = S_MASK;
            end
          end else if (in_key_code == mle_pkg::KEY_PREFIX0 ||
                       in_key_code == mle_pkg::KEY_PREFIX1) begin
            pend_nxt = 1'b1;
          end else if (in_key_code == mle_pkg::KEY_ENTER) begin
            op_nxt    = OP_ENTER;
            cnt_nxt   = len_r;
            len_nxt   = '0;
            cur_nxt   = '0;
            state_nxt = (len_r != '0) ? S_TEXT : S_END;
          end else if (in_key_code == mle_pkg::KEY_BKSP && cur_r != '0) begin
            cell_ctl.op = mle_pkg::CELL_DEL;
            cur_nxt     = cur_r - ONE;
            len_nxt     = len_r - ONE;
            tail_nxt    = len_r - cur_r;
            op_nxt      = OP_BKSP;
            state_nxt   = S_PRE8;
          end else if (printable && len_r < CAP) begin
            cell_ctl.op = mle_pkg::CELL_INS;
            cur_nxt     = cur_r + ONE;
            len_nxt     = len_r + ONE;
            tail_nxt    = len_r - cur_r;
            cnt_nxt     = len_r - cur_r + ONE;
            op_nxt      = OP_INS;
            state_nxt   = S_MASK;
          end
        end
      end
      S_PRE8: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mle_pkg::KIND_ECHO;
          out_byte_nxt  = mle_pkg::KEY_BKSP;
          out_last_nxt  = 1'b0;
          if (op_r == OP_LEFT) begin
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else if (tail_r != '0) begin
            cnt_nxt   = tail_r;
            state_nxt = S_MASK;
          end else begin
            state_nxt = S_SPACE;
          end
        end
      end
      S_MASK: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mle_pkg::KIND_ECHO;
          out_byte_nxt  = mask_char;
          out_last_nxt  = 1'b0;
          cnt_nxt       = cnt_r - ONE;
          if (cnt_r == ONE) begin
            if (op_r == OP_BKSP) begin
              state_nxt = S_SPACE;
            end else if (op_r == OP_INS && tail_r != '0) begin
              cnt_nxt   = tail_r;
              state_nxt = S_BSN;
            end else begin
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        end
      end
      S_SPACE: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mle_pkg::KIND_ECHO;
          out_byte_nxt  = mle_pkg::KEY_SPACE;
          out_last_nxt  = 1'b0;
          state_nxt     = S_BS1;
        end
      end
      S_BS1: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mle_pkg::KIND_ECHO;
          out_byte_nxt  = mle_pkg::KEY_BKSP;
          if (tail_r != '0) begin
            out_last_nxt = 1'b0;
            cnt_nxt      = tail_r;
            state_nxt    = S_BSN;
          end else begin
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_BSN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mle_pkg::KIND_ECHO;
          out_byte_nxt  = mle_pkg::KEY_BKSP;
          out_last_nxt  = (cnt_r == ONE);
          cnt_nxt       = cnt_r - ONE;
          if (cnt_r == ONE) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_TEXT: begin
        if (adv) begin
          cell_ctl.op   = mle_pkg::CELL_SHL;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mle_pkg::KIND_TEXT;
          out_byte_nxt  = {1'b0, head_char};
          out_last_nxt  = 1'b0;
          cnt_nxt       = cnt_r - ONE;
          if (cnt_r == ONE) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mle_pkg::KIND_END;
          out_byte_nxt  = mle_pkg::END_BYTE;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cur_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cnt_r      <= cnt_nxt;
    tail_r     <= tail_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/masked_line_editor_unit.sv =====
`default_nettype none
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_key_code
// out      output     out_valid, out_stall, out_kind, out_byte, out_last
// cfg      input      cfg_we, cfg_wdata (mask character)
//
// A key is taken while in_stall is low; its results then leave at one per cycle while
// the output is not stalled, n results per key (n at most 2*CAPACITY+1), issued by the
// sequencer into the output register. in_stall stays high until the last result is
// loaded; a stalled output holds the sequencer. Enter streams the text out of the cell
// row by shifting it left one cell per result.
// Reset clears length, cursor and prefix flag and sets the mask to 42; the text cells
// are not cleared.

module masked_line_editor_unit #(
  parameter int CAPACITY = mle_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mle_pkg::BYTE_W-1:0]  in_key_code,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [mle_pkg::KIND_W-1:0]  out_kind,
  output logic      [mle_pkg::BYTE_W-1:0]  out_byte,
  output logic                             out_last,
  input  wire logic                        cfg_we,
  input  wire logic [mle_pkg::BYTE_W-1:0]  cfg_wdata
);

  logic [mle_pkg::BYTE_W-1:0] mask_r;
  logic [mle_pkg::BYTE_W-1:0] mask_nxt;
  mle_pkg::cell_ctl_t         cell_ctl;
  logic [mle_pkg::CHAR_W-1:0] cell_q [CAPACITY];

  assign mask_nxt = cfg_we ? cfg_wdata : mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= mle_pkg::MASK_RESET;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [mle_pkg::CHAR_W-1:0] left_d;
    logic [mle_pkg::CHAR_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_lastc
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    mle_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .left_in  (left_d),
      .right_in (right_d),
      .data_out (cell_q[g])
    );
  end

  mle_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_key_code (in_key_code),
    .mask_char   (mask_r),
    .head_char   (cell_q[0]),
    .cell_ctl    (cell_ctl),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

// ===== hdl/mle_checker.sv =====
`default_nettype none

module mle_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [mle_pkg::KIND_W-1:0] out_kind,
  input wire logic [mle_pkg::BYTE_W-1:0] out_byte,
  input wire logic                       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_last))
    else $error("output changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mle_pkg::KIND_END |-> out_last && out_byte == mle_pkg::END_BYTE)
    else $error("end of line not final or not zero");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input open before final result issued");

  a_text7: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mle_pkg::KIND_TEXT |-> !out_byte[7] && !out_last)
    else $error("bad text transfer");

endmodule

bind masked_line_editor_unit mle_checker u_mle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

`default_nettype wire

// ===== dv/masked_line_editor_unit_tb.sv =====
`timescale 1ns / 1ps

module masked_line_editor_unit_tb;

  localparam int CAPACITY      = mle_pkg::CAPACITY_DEF;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int CYCLE_LIMIT   = 500_000;

  typedef struct packed {
    logic [mle_pkg::KIND_W-1:0] kind;
    logic [mle_pkg::BYTE_W-1:0] data;
    logic                       last;
  } line_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [mle_pkg::BYTE_W-1:0] in_key_code;
  logic                       out_valid;
  logic                       out_stall;
  logic [mle_pkg::KIND_W-1:0] out_kind;
  logic [mle_pkg::BYTE_W-1:0] out_byte;
  logic                       out_last;
  logic                       cfg_we;
  logic [mle_pkg::BYTE_W-1:0] cfg_wdata;

  logic [mle_pkg::CHAR_W-1:0] shadow_text [CAPACITY];
  int                         shadow_len;
  int                         shadow_cursor;
  bit                         shadow_prefixed;
  logic [mle_pkg::BYTE_W-1:0] shadow_mask;

  line_result_t      echo_and_text_q [$];
  int                mismatch_count;
  int                keys_effective;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_left;
  int                cycle_count;

  masked_line_editor_unit #(.CAPACITY(CAPACITY)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_key_code(in_key_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("masked_line_editor_unit_tb: errors");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (echo_and_text_q.size() == 0) begin
        $error("out_kind: expected no transfer, actual %0d (out_byte %0d)", out_kind, out_byte);
        mismatch_count++;
      end else begin
        want = echo_and_text_q.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
          mismatch_count++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0d, actual %0d", want.data, out_byte);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, actual %0d", want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic edit_line(input logic [mle_pkg::BYTE_W-1:0] code, output int produced,
                           output bit took_effect);
    line_result_t burst [$];
    line_result_t r;
    int           i;
    took_effect = 1'b0;
    if (shadow_prefixed) begin
      shadow_prefixed = 1'b0;
      took_effect = 1'b1;
      if (code == mle_pkg::KEY_LEFT && shadow_cursor > 0) begin
        burst.push_back('{mle_pkg::KIND_ECHO, mle_pkg::KEY_BKSP, 1'b0});
        shadow_cursor--;
      end else if (code == mle_pkg::KEY_RIGHT && shadow_cursor < shadow_len) begin
        burst.push_back('{mle_pkg::KIND_ECHO, shadow_mask, 1'b0});
        shadow_cursor++;
      end
    end else if (code == mle_pkg::KEY_PREFIX0 || code == mle_pkg::KEY_PREFIX1) begin
      shadow_prefixed = 1'b1;
      took_effect = 1'b1;
    end else if (code == mle_pkg::KEY_ENTER) begin
      for (i = 0; i < shadow_len; i++)
        burst.push_back('{mle_pkg::KIND_TEXT, {1'b0, shadow_text[i]}, 1'b0});
      burst.push_back('{mle_pkg::KIND_END, mle_pkg::END_BYTE, 1'b0});
      shadow_len = 0;
      shadow_cursor = 0;
    end else if (code == mle_pkg::KEY_BKSP && shadow_cursor > 0) begin
      shadow_cursor--;
      shadow_len--;
      for (i = shadow_cursor; i < shadow_len; i++)
        shadow_text[i] = shadow_text[i + 1];
      burst.push_back('{mle_pkg::KIND_ECHO, mle_pkg::KEY_BKSP, 1'b0});
      for (i = shadow_cursor; i < shadow_len; i++)
        burst.push_back('{mle_pkg::KIND_ECHO, shadow_mask, 1'b0});
      burst.push_back('{mle_pkg::KIND_ECHO, mle_pkg::KEY_SPACE, 1'b0});
      burst.push_back('{mle_pkg::KIND_ECHO, mle_pkg::KEY_BKSP, 1'b0});
      for (i = shadow_cursor; i < shadow_len; i++)
        burst.push_back('{mle_pkg::KIND_ECHO, mle_pkg::KEY_BKSP, 1'b0});
    end else if (code >= mle_pkg::KEY_SPACE && code <= mle_pkg::KEY_TILDE &&
                 shadow_len < CAPACITY) begin
      for (i = shadow_len; i > shadow_cursor; i--)
        shadow_text[i] = shadow_text[i - 1];
      shadow_text[shadow_cursor] = code[mle_pkg::CHAR_W-1:0];
      shadow_len++;
      for (i = shadow_cursor; i < shadow_len; i++)
        burst.push_back('{mle_pkg::KIND_ECHO, shadow_mask, 1'b0});
      for (i = shadow_cursor + 1; i < shadow_len; i++)
        burst.push_back('{mle_pkg::KIND_ECHO, mle_pkg::KEY_BKSP, 1'b0});
      shadow_cursor++;
    end
    produced = burst.size();
    if (produced > 0)
      took_effect = 1'b1;
    for (i = 0; i < produced; i++) begin
      r = burst[i];
      r.last = (i == produced - 1);
      echo_and_text_q.push_back(r);
    end
  endtask

  task automatic send_key(input logic [mle_pkg::BYTE_W-1:0] code);
    int produced;
    bit took_effect;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_key_code <= code;
    do @(posedge clk); while (in_stall);
    edit_line(code, produced, took_effect);
    if (took_effect)
      keys_effective++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (echo_and_text_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [mle_pkg::BYTE_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_mask = value;
  endtask

  task automatic test_basic_edits();
    send_key(mle_pkg::KEY_BKSP);
    send_key(mle_pkg::KEY_ENTER);
    send_key(8'd31);
    send_key(8'd127);
    send_key(8'd255);
    send_key(mle_pkg::KEY_SPACE);
    send_key(mle_pkg::KEY_TILDE);
    send_key(mle_pkg::KEY_PREFIX1);
    send_key(mle_pkg::KEY_LEFT);
    send_key(mle_pkg::KEY_PREFIX0);
    send_key(mle_pkg::KEY_LEFT);
    send_key(mle_pkg::KEY_PREFIX0);
    send_key(mle_pkg::KEY_LEFT);
    send_key(mle_pkg::KEY_PREFIX1);
    send_key(mle_pkg::KEY_RIGHT);
    send_key(mle_pkg::KEY_PREFIX1);
    send_key(mle_pkg::KEY_ENTER);
    send_key(mle_pkg::KEY_PREFIX0);
    send_key(mle_pkg::KEY_PREFIX0);
    send_key(mle_pkg::KEY_PREFIX1);
    send_key(mle_pkg::KEY_PREFIX1);
    send_key(mle_pkg::KEY_PREFIX0);
    send_key(mle_pkg::KEY_BKSP);
    send_key(8'd65);
    send_key(mle_pkg::KEY_BKSP);
    send_key(mle_pkg::KEY_ENTER);
  endtask

  task automatic test_full_line();
    int i;
    for (i = 0; i <= CAPACITY; i++)
      send_key(8'($urandom_range(mle_pkg::KEY_SPACE, mle_pkg::KEY_TILDE)));
    send_key(mle_pkg::KEY_TILDE);
    send_key(mle_pkg::KEY_PREFIX1);
    send_key(mle_pkg::KEY_RIGHT);
    for (i = 0; i < 3; i++) begin
      send_key(mle_pkg::KEY_PREFIX0);
      send_key(mle_pkg::KEY_LEFT);
    end
    send_key(mle_pkg::KEY_BKSP);
    send_key(8'd90);
    send_key(mle_pkg::KEY_ENTER);
  endtask

  task automatic test_random_lines(input int target);
    int stop_at;
    int nkeys;
    int k;
    int pick;
    stop_at = keys_effective + target;
    while (keys_effective < stop_at) begin
      nkeys = $urandom_range(1, 24);
      for (k = 0; k < nkeys; k++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_key(8'($urandom_range(mle_pkg::KEY_SPACE, mle_pkg::KEY_TILDE)));
        end else if (pick < 60) begin
          send_key(mle_pkg::KEY_BKSP);
        end else if (pick < 78) begin
          send_key($urandom_range(1) ? mle_pkg::KEY_PREFIX1 : mle_pkg::KEY_PREFIX0);
          send_key($urandom_range(1) ? mle_pkg::KEY_RIGHT : mle_pkg::KEY_LEFT);
        end else if (pick < 82) begin
          send_key($urandom_range(1) ? mle_pkg::KEY_PREFIX1 : mle_pkg::KEY_PREFIX0);
          send_key(8'($urandom_range(255)));
        end else if (pick < 90) begin
          send_key(8'($urandom_range(255)));
        end else begin
          send_key($urandom_range(1) ? mle_pkg::KEY_TILDE : mle_pkg::KEY_SPACE);
        end
      end
      if ($urandom_range(9) != 0)
        send_key(mle_pkg::KEY_ENTER);
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    hold_left = 400;
    for (i = 0; i < 14; i++)
      send_key(8'($urandom_range(mle_pkg::KEY_SPACE, mle_pkg::KEY_TILDE)));
    send_key(mle_pkg::KEY_ENTER);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    test_random_lines(30);
    wait_drained();
    test_random_lines(30);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_key_code    <= '0;
    out_stall      <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    mismatch_count = 0;
    keys_effective = 0;
    hold_left      = 0;
    cycle_count    = 0;
    send_idle_pct  = 33;
    recv_stall_pct = 61;
    shadow_len      = 0;
    shadow_cursor   = 0;
    shadow_prefixed = 1'b0;
    shadow_mask     = mle_pkg::MASK_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_edits();
    test_full_line();

    write_mask(8'h00);
    test_random_lines(120);

    write_mask(8'hFF);
    send_idle_pct  = 61;
    recv_stall_pct = 33;
    test_random_lines(120);

    write_mask(8'($urandom_range(1, 254)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_output_backpressure();
    test_sender_pause();
    test_random_lines(60);

    wait_drained();
    if (mismatch_count == 0)
      $display("masked_line_editor_unit_tb: clean");
    else
      $display("masked_line_editor_unit_tb: errors");
    $finish;
  end

endmodule
